// File: design/satl_pkg.sv
package satl_pkg;

    localparam int TILE_COUNT_DEF    = 64;
    localparam int TILES_PER_ROW_DEF = 8;
    localparam int TILE_SIZE_DEF     = 512;

    localparam int NUM_PLANES = 6;
    localparam int CUBE_FACES = 6;

    localparam int CFG_IW = 3;
    localparam logic [CFG_IW-1:0] CFG_CAMERA_ROW0     = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_CAMERA_ROW1     = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_CAMERA_ROW2     = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_CAMERA_ROW3     = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_MAX_SPOT_ANGLE  = 3'd4;

    typedef enum logic [1:0] {
        OC_TILE,
        OC_NOSHADOW,
        OC_CULLED,
        OC_DROPPED
    } t_outcome;

    typedef enum logic [1:0] {
        LT_NONLOCAL,
        LT_POINT,
        LT_SPOT,
        LT_AREA
    } t_light_type;

    typedef struct packed {
        logic               first_of_frame;
        t_light_type        light_type;
        logic               casts_shadows;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic [15:0]        light_range;
        logic [15:0]        outer_angle;
    } t_in;

    typedef struct packed {
        t_outcome    outcome;
        logic [5:0]  tile_index;
        logic [11:0] offset_x;
        logic [11:0] offset_y;
        logic [2:0]  face;
        logic        is_cube;
        logic [15:0] dropped_count;
        logic        last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VEC,
        S_MUL1,
        S_SUM1,
        S_MUL2,
        S_SUM2,
        S_CMP,
        S_DECIDE,
        S_LOAD,
        S_WAIT
    } t_state;

    typedef struct packed {
        logic     load_item;
        logic     plane_clr;
        logic     plane_inc;
        logic     set_kind;
        t_outcome kind;
        logic     decide;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic skip_in;
        logic plane_skip;
        logic cull_hit;
        logic last_plane;
        logic out_done;
        logic out_last;
    } t_status;

    function automatic logic signed [15:0] mat_entry(input logic [63:0] row,
                                                      input logic [1:0] col);
        logic signed [15:0] e;
        case (col)
            2'd0:    e = row[15:0];
            2'd1:    e = row[31:16];
            2'd2:    e = row[47:32];
            default: e = row[63:48];
        endcase
        return e;
    endfunction

endpackage

// File: design/satl_ctrl.sv
module satl_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  satl_pkg::t_status i_status,
    output satl_pkg::t_cmd    o_cmd
);
    import satl_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_status.skip_in ? S_LOAD : S_VEC;
                end
            end
            S_VEC:  n_state = S_MUL1;
            S_MUL1: n_state = S_SUM1;
            S_SUM1: n_state = S_MUL2;
            S_MUL2: begin
                if (i_status.plane_skip) begin
                    n_state = i_status.last_plane ? S_DECIDE : S_VEC;
                end else begin
                    n_state = S_SUM2;
                end
            end
            S_SUM2: n_state = S_CMP;
            S_CMP: begin
                if (i_status.cull_hit) begin
                    n_state = S_LOAD;
                end else begin
                    n_state = i_status.last_plane ? S_DECIDE : S_VEC;
                end
            end
            S_DECIDE: n_state = S_LOAD;
            S_LOAD:   n_state = S_WAIT;
            S_WAIT: begin
                if (i_status.out_done) begin
                    n_state = i_status.out_last ? S_IDLE : S_LOAD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_cmd.kind = OC_TILE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.plane_clr = 1'b1;
                    o_cmd.set_kind  = i_status.skip_in;
                    o_cmd.kind      = OC_NOSHADOW;
                end
            end
            S_MUL2: begin
                o_cmd.plane_inc = i_status.plane_skip && !i_status.last_plane;
            end
            S_CMP: begin
                o_cmd.set_kind  = i_status.cull_hit;
                o_cmd.kind      = OC_CULLED;
                o_cmd.plane_inc = !i_status.cull_hit && !i_status.last_plane;
            end
            S_DECIDE: o_cmd.decide   = 1'b1;
            S_LOAD:   o_cmd.load_out = 1'b1;
            default: begin
            end
        endcase
    end

endmodule

// File: design/satl_dp.sv
module satl_dp #(
    parameter int TILE_COUNT    = satl_pkg::TILE_COUNT_DEF,
    parameter int TILES_PER_ROW = satl_pkg::TILES_PER_ROW_DEF,
    parameter int TILE_SIZE     = satl_pkg::TILE_SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  satl_pkg::t_in                 i_in_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [satl_pkg::CFG_IW-1:0]   i_cfg_index,
    input  logic [63:0]                   i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output satl_pkg::t_out                o_out_data,
    input  satl_pkg::t_cmd                i_cmd,
    output satl_pkg::t_status             o_status
);
    import satl_pkg::*;

    localparam int TW = $clog2(TILE_COUNT + 1);
    localparam int CW = (TILES_PER_ROW > 1) ? $clog2(TILES_PER_ROW) : 1;

    logic [63:0] r_cam [4];
    logic [15:0] r_max_angle;

    t_in         r_item;
    logic [2:0]  r_plane;
    t_outcome    r_kind;
    logic        r_cube;
    logic [TW-1:0] r_next;
    logic [CW-1:0] r_col;
    logic [TW-1:0] r_row;
    logic [15:0] r_drop;
    logic [2:0]  r_face;
    logic        r_o_valid;
    t_out        r_out;

    logic signed [16:0] n_v [4];
    logic signed [16:0] r_v [4];
    logic signed [33:0] r_sq [3];
    logic signed [32:0] r_pr [3];
    logic signed [20:0] r_w;
    logic [33:0]        r_len2;
    logic signed [33:0] r_s;
    logic [31:0]        r_r2;
    logic [31:0]        r_m_hh;
    logic [33:0]        r_m_hl;
    logic [35:0]        r_m_ll;
    logic [63:0]        r_q_lo;
    logic [33:0]        r_q_hi;
    logic [67:0]        r_lhs;
    logic [67:0]        r_rhs;

    logic [33:0]        mag;
    logic signed [15:0] pos [3];
    logic               cube;
    logic [TW:0]        needed;
    logic               need_drop;
    logic               tile_last;
    logic [31:0]        ox_full;
    logic [31:0]        oy_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_cam[i] <= '0;
            end
            r_max_angle <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CAMERA_ROW0:    r_cam[0]    <= i_cfg_data;
                CFG_CAMERA_ROW1:    r_cam[1]    <= i_cfg_data;
                CFG_CAMERA_ROW2:    r_cam[2]    <= i_cfg_data;
                CFG_CAMERA_ROW3:    r_cam[3]    <= i_cfg_data;
                CFG_MAX_SPOT_ANGLE: r_max_angle <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    assign pos[0] = r_item.pos_x;
    assign pos[1] = r_item.pos_y;
    assign pos[2] = r_item.pos_z;

    always_comb begin
        for (int j = 0; j < 4; j++) begin
            logic signed [16:0] e3;
            e3 = 17'(mat_entry(r_cam[3], 2'(j)));
            case (r_plane)
                3'd0:    n_v[j] = e3 + 17'(mat_entry(r_cam[0], 2'(j)));
                3'd1:    n_v[j] = e3 - 17'(mat_entry(r_cam[0], 2'(j)));
                3'd2:    n_v[j] = e3 + 17'(mat_entry(r_cam[1], 2'(j)));
                3'd3:    n_v[j] = e3 - 17'(mat_entry(r_cam[1], 2'(j)));
                3'd4:    n_v[j] = 17'(mat_entry(r_cam[2], 2'(j)));
                default: n_v[j] = e3 - 17'(mat_entry(r_cam[2], 2'(j)));
            endcase
        end
    end

    assign mag = 34'(-r_s);

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            r_v[j] <= n_v[j];
        end
        for (int j = 0; j < 3; j++) begin
            r_sq[j] <= r_v[j] * r_v[j];
            r_pr[j] <= r_v[j] * 33'(pos[j]);
        end
        r_w    <= 21'(r_v[3]) <<< 4;
        r_len2 <= 34'(r_sq[0]) + 34'(r_sq[1]) + 34'(r_sq[2]);
        r_s    <= 34'(r_pr[0]) + 34'(r_pr[1]) + 34'(r_pr[2]) + 34'(r_w);
        r_r2   <= 32'(r_item.light_range) * 32'(r_item.light_range);
        r_m_hh <= 32'(mag[33:18]) * 32'(mag[33:18]);
        r_m_hl <= 34'(mag[33:18]) * 34'(mag[17:0]);
        r_m_ll <= 36'(mag[17:0]) * 36'(mag[17:0]);
        r_q_lo <= 64'(r_r2) * 64'(r_len2[31:0]);
        r_q_hi <= 34'(r_r2) * 34'(r_len2[33:32]);
        r_lhs  <= (68'(r_m_hh) << 36) + (68'(r_m_hl) << 19) + 68'(r_m_ll);
        r_rhs  <= 68'(r_q_lo) + (68'(r_q_hi) << 32);
    end

    assign cube      = (r_item.light_type != LT_SPOT) || (r_item.outer_angle > r_max_angle);
    assign needed    = cube ? (TW+1)'(CUBE_FACES) : (TW+1)'(1);
    assign need_drop = ({1'b0, r_next} + needed) > (TW+1)'(TILE_COUNT);
    assign tile_last = !r_cube || (r_face == 3'(CUBE_FACES - 1));
    assign ox_full   = 32'(r_col) * 32'(TILE_SIZE);
    assign oy_full   = 32'(r_row) * 32'(TILE_SIZE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.set_kind) begin
            r_kind <= i_cmd.kind;
        end else if (i_cmd.decide) begin
            r_kind <= need_drop ? OC_DROPPED : OC_TILE;
        end
        if (i_cmd.decide) begin
            r_cube <= cube;
        end
        if (i_cmd.load_out) begin
            r_out.outcome       <= r_kind;
            r_out.dropped_count <= r_drop;
            if (r_kind == OC_TILE) begin
                r_out.tile_index <= 6'(r_next);
                r_out.offset_x   <= ox_full[11:0];
                r_out.offset_y   <= oy_full[11:0];
                r_out.face       <= r_face;
                r_out.is_cube    <= r_cube;
                r_out.last       <= tile_last;
            end else begin
                r_out.tile_index <= '0;
                r_out.offset_x   <= '0;
                r_out.offset_y   <= '0;
                r_out.face       <= '0;
                r_out.is_cube    <= 1'b0;
                r_out.last       <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane   <= '0;
            r_next    <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_drop    <= '0;
            r_face    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cmd.plane_clr) begin
                r_plane <= '0;
            end else if (i_cmd.plane_inc) begin
                r_plane <= r_plane + 3'd1;
            end
            if (i_cmd.load_item && i_in_data.first_of_frame) begin
                r_next <= '0;
                r_col  <= '0;
                r_row  <= '0;
                r_drop <= '0;
            end else if (i_cmd.decide && need_drop && (r_drop != 16'hFFFF)) begin
                r_drop <= r_drop + 16'd1;
            end else if (i_cmd.load_out && (r_kind == OC_TILE)) begin
                r_next <= r_next + TW'(1);
                if (r_col == CW'(TILES_PER_ROW - 1)) begin
                    r_col <= '0;
                    r_row <= r_row + TW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end
            if (i_cmd.decide) begin
                r_face <= '0;
            end else if (i_cmd.load_out && (r_kind == OC_TILE)) begin
                r_face <= r_face + 3'd1;
            end
            if (i_cmd.load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_out;

    assign o_status.skip_in    = (i_in_data.light_type == LT_NONLOCAL) ||
                                 !i_in_data.casts_shadows ||
                                 (i_in_data.light_range == 16'd0);
    assign o_status.plane_skip = (r_len2 == '0) || !r_s[33];
    assign o_status.cull_hit   = r_lhs > r_rhs;
    assign o_status.last_plane = (r_plane == 3'(NUM_PLANES - 1));
    assign o_status.out_done   = r_o_valid && i_out_ready;
    assign o_status.out_last   = r_out.last;

endmodule

// File: design/shadow_atlas_tile_allocator.sv
// channel | valid      | ready       | payload
// input   | i_in_valid | o_in_ready  | i_in_data  (t_in)
// result  | o_out_valid| i_out_ready | o_out_data (t_out)
// config  | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// One light at a time: accept, then each frustum plane through the shared
// multiply and sum registers (no compare for a zero normal or non-negative
// distance), a decide step unless a plane culled, then each result loaded and
// held through any output stall; an unshadowed light skips to its result.
// Input is held off until the last result is taken. Synchronous active-low
// reset clears counters, config and control; config is always ready.
module shadow_atlas_tile_allocator #(
    parameter int TILE_COUNT    = satl_pkg::TILE_COUNT_DEF,
    parameter int TILES_PER_ROW = satl_pkg::TILES_PER_ROW_DEF,
    parameter int TILE_SIZE     = satl_pkg::TILE_SIZE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  satl_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output satl_pkg::t_out              o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [satl_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [63:0]                 i_cfg_data
);
    import satl_pkg::*;

    t_cmd    cmd;
    t_status status;

    satl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    satl_dp #(
        .TILE_COUNT    (TILE_COUNT),
        .TILES_PER_ROW (TILES_PER_ROW),
        .TILE_SIZE     (TILE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input ready while a result is pending");

    a_no_tile_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.outcome != OC_TILE)) |->
            (o_out_data.last && !o_out_data.is_cube && (o_out_data.face == 3'd0)))
        else $error("non-tile result not single");

    a_spot_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.outcome == OC_TILE) && !o_out_data.is_cube) |->
            (o_out_data.last && (o_out_data.face == 3'd0)))
        else $error("spot tile not single");

    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.face <= 3'(CUBE_FACES - 1)))
        else $error("cube face out of range");

endmodule
